// File: design/tea_block_cipher_top_macros.svh
// Assertion macros shared by the checker files of the TEA cipher block.
`ifndef TEA_BLOCK_CIPHER_TOP_MACROS_SVH
`define TEA_BLOCK_CIPHER_TOP_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define TEA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define TEA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: design/tea_pkg.sv
// Types, constants and register indexes of the TEA cipher block.
package tea_pkg;

  localparam int unsigned ROUNDS    = 32;
  localparam int unsigned NUM_CELLS = 2 * ROUNDS;

  localparam logic [31:0] DELTA = 32'h9E37_79B9;
  localparam logic [63:0] DEC_SUM_FULL = 64'(DELTA) * 64'(ROUNDS);
  localparam logic [31:0] DEC_SUM0 = DEC_SUM_FULL[31:0];

  localparam logic [31:0] KEY0_RESET = 32'h3B39_8E26;
  localparam logic [31:0] KEY1_RESET = 32'h40C2_9501;
  localparam logic [31:0] KEY2_RESET = 32'h614D_7630;
  localparam logic [31:0] KEY3_RESET = 32'h7F59_409A;

  localparam int unsigned ADDR_W = 4;

  localparam logic [1:0] KEY0_IDX = 2'd0;
  localparam logic [1:0] KEY1_IDX = 2'd1;
  localparam logic [1:0] KEY2_IDX = 2'd2;
  localparam logic [1:0] KEY3_IDX = 2'd3;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
  } key_t;

  typedef struct packed {
    logic        op;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] sum;
  } stage_t;

endpackage

// File: design/tea_cfg.sv
// APB register file holding the four 32-bit words of the 128-bit key.
module tea_cfg
  import tea_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output key_t              key_o
);

  key_t       key_q;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[ADDR_W-1:2];
  assign key_o  = key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q.w0 <= KEY0_RESET;
      key_q.w1 <= KEY1_RESET;
      key_q.w2 <= KEY2_RESET;
      key_q.w3 <= KEY3_RESET;
    end else if (wr_en) begin
      case (idx)
        KEY0_IDX: key_q.w0 <= pwdata;
        KEY1_IDX: key_q.w1 <= pwdata;
        KEY2_IDX: key_q.w2 <= pwdata;
        KEY3_IDX: key_q.w3 <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      KEY0_IDX: prdata = key_q.w0;
      KEY1_IDX: prdata = key_q.w1;
      KEY2_IDX: prdata = key_q.w2;
      KEY3_IDX: prdata = key_q.w3;
      default:  prdata = '0;
    endcase
  end

endmodule

// File: design/tea_cell.sv
// One half round of TEA, registered, as a link in the round chain.
module tea_cell
  import tea_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   phase_i,
  input  key_t   key_i,
  input  logic   valid_i,
  input  stage_t data_i,
  output logic   valid_o,
  output stage_t data_o
);

  logic        valid_q;
  stage_t      data_q;
  stage_t      data_d;
  logic        sel_left;
  logic [31:0] x;
  logic [31:0] ka;
  logic [31:0] kb;
  logic [31:0] mix;
  logic [31:0] target;
  logic [31:0] updated;

  // Encryption updates left then right; decryption runs the halves the other
  // way round, so one select covers both source word and key pair.
  always_comb begin
    sel_left = data_i.op ^ phase_i;
    x        = sel_left ? data_i.l : data_i.r;
    target   = sel_left ? data_i.r : data_i.l;
    ka       = sel_left ? key_i.w2 : key_i.w0;
    kb       = sel_left ? key_i.w3 : key_i.w1;
    mix      = ((x << 4) + ka) ^ (x + data_i.sum) ^ ((x >> 5) + kb);
    updated  = (data_i.op == OP_DECRYPT) ? (target - mix) : (target + mix);

    data_d = data_i;
    if (sel_left) begin
      data_d.r = updated;
    end else begin
      data_d.l = updated;
    end
    if (phase_i) begin
      data_d.sum = (data_i.op == OP_DECRYPT) ? (data_i.sum - DELTA)
                                             : (data_i.sum + DELTA);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: design/tea_block_cipher_top.sv
// Top level of the TEA block cipher: key registers and the chain of round cells.
//
// Each request carries one 64-bit block and an encrypt or decrypt selector and
// yields one transformed block. The block passes through a chain of 64 cells,
// one half round each (two per round over 32 rounds), and a new block is taken
// every cycle while the output is not stalled. The last cell is the output
// register; while its result is held back by the sink the whole chain stands
// still and no request is taken. The key is written over the APB port and
// must only change while no block is in the chain.
module tea_block_cipher_top
  import tea_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,  // word_left [31:0], word_right [63:32]
  input  logic [0:0]        s_axis_tuser,  // req_type [0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [63:0]       m_axis_tdata,  // result_left [31:0], result_right [63:32]
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  key_t   key;
  logic   advance;
  logic   valid_chain [NUM_CELLS+1];
  stage_t data_chain  [NUM_CELLS+1];

  tea_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key_o   (key)
  );

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  assign valid_chain[0] = s_axis_tvalid;
  assign data_chain[0]  = '{
    op:  s_axis_tuser[0],
    l:   s_axis_tdata[31:0],
    r:   s_axis_tdata[63:32],
    sum: (s_axis_tuser[0] == OP_DECRYPT) ? DEC_SUM0 : DELTA
  };

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    tea_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .phase_i (1'(k % 2)),
      .key_i   (key),
      .valid_i (valid_chain[k]),
      .data_i  (data_chain[k]),
      .valid_o (valid_chain[k+1]),
      .data_o  (data_chain[k+1])
    );
  end

  assign m_axis_tvalid = valid_chain[NUM_CELLS];
  assign m_axis_tdata  = {data_chain[NUM_CELLS].r, data_chain[NUM_CELLS].l};

endmodule

// File: design/tea_block_cipher_checker.sv
// Port-level assertions for the TEA cipher top level, bound to it.
`include "tea_block_cipher_top_macros.svh"

module tea_block_cipher_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        pready
);

  // The chain takes a request exactly when its output register can move on.
  `TEA_ASSERT(a_ready_follows_sink, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not track output stall")

  // A stalled result stays in place with its data.
  `TEA_ASSERT(a_stall_holds, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

  // No result can reach the output in the cycle after reset.
  `TEA_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid, "result shown straight after reset")

  // The register port never inserts wait states.
  `TEA_ASSERT_ALWAYS(a_pready_high, rst_ni |-> pready, "pready dropped")

endmodule

bind tea_block_cipher_top tea_block_cipher_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);

// File: test/tb_tea_block_ledger_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the TEA cipher testbench: key copy, cipher predictor and result checks.
package tb_tea_block_ledger_pkg;
  import tea_pkg::*;

  localparam logic [31:0] TB_TEA_DELTA  = 32'h9E37_79B9;
  localparam int unsigned TB_TEA_ROUNDS = 32;

  typedef struct {
    logic [31:0] left;
    logic [31:0] right;
  } cipher_block_t;

  class tea_block_ledger;
    logic [31:0]   key_words [4];
    cipher_block_t pending_blocks [$];
    int unsigned   fail_count;
    int unsigned   blocks_noted;
    int unsigned   decrypt_count;
    int unsigned   blocks_checked;

    function new();
      key_words[0]   = 32'h3B39_8E26;
      key_words[1]   = 32'h40C2_9501;
      key_words[2]   = 32'h614D_7630;
      key_words[3]   = 32'h7F59_409A;
      fail_count     = 0;
      blocks_noted   = 0;
      decrypt_count  = 0;
      blocks_checked = 0;
    endfunction

    function void set_key(int unsigned idx, logic [31:0] value);
      if (idx < 4) begin
        key_words[idx] = value;
      end
    endfunction

    function logic [31:0] half_mix(logic [31:0] x, logic [31:0] sum,
                                   logic [31:0] ka, logic [31:0] kb);
      return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    endfunction

    function cipher_block_t cipher_block(logic op, logic [31:0] left, logic [31:0] right);
      cipher_block_t res;
      logic [31:0]   sum;
      logic [31:0]   l;
      logic [31:0]   r;
      int unsigned   i;
      l = left;
      r = right;
      if (op == OP_ENCRYPT) begin
        sum = '0;
        for (i = 0; i < TB_TEA_ROUNDS; i++) begin
          sum = sum + TB_TEA_DELTA;
          l   = l + half_mix(r, sum, key_words[0], key_words[1]);
          r   = r + half_mix(l, sum, key_words[2], key_words[3]);
        end
      end else begin
        // Decryption starts from the sum that encryption ends with.
        sum = TB_TEA_DELTA * 32'(TB_TEA_ROUNDS);
        for (i = 0; i < TB_TEA_ROUNDS; i++) begin
          r   = r - half_mix(l, sum, key_words[2], key_words[3]);
          l   = l - half_mix(r, sum, key_words[0], key_words[1]);
          sum = sum - TB_TEA_DELTA;
        end
      end
      res.left  = l;
      res.right = r;
      return res;
    endfunction

    function void note_request(logic op, logic [31:0] left, logic [31:0] right);
      pending_blocks.push_back(cipher_block(op, left, right));
      blocks_noted++;
      if (op == OP_DECRYPT) begin
        decrypt_count++;
      end
    endfunction

    function void check_block(logic [31:0] left, logic [31:0] right);
      cipher_block_t want;
      if (pending_blocks.size() == 0) begin
        $error("result with no request outstanding: left %h right %h", left, right);
        fail_count++;
        return;
      end
      want = pending_blocks.pop_front();
      blocks_checked++;
      if (left !== want.left) begin
        $error("result_left: expected %h, actual %h", want.left, left);
        fail_count++;
      end
      if (right !== want.right) begin
        $error("result_right: expected %h, actual %h", want.right, right);
        fail_count++;
      end
    endfunction

    function void check_key_readback(int unsigned idx, logic [31:0] value);
      if (value !== key_words[idx]) begin
        $error("key_word%0d: expected %h, actual %h", idx, key_words[idx], value);
        fail_count++;
      end
    endfunction
  endclass

endpackage

// File: test/tb_tea_block_cipher_top.sv
`timescale 1ns / 100ps
// Testbench of the TEA block cipher top level: random traffic, key changes and back-pressure.
module tb_tea_block_cipher_top;
  import tea_pkg::*;
  import tb_tea_block_ledger_pkg::*;

  localparam int unsigned SINK_HOLD_CYCLES = 400;
  localparam logic [1:0]  KEY_IDX_LIST [4] = '{KEY0_IDX, KEY1_IDX, KEY2_IDX, KEY3_IDX};
  // Edge blocks, written as {word_right, word_left}.
  localparam logic [63:0] EDGE_BLOCKS [7] = '{
    64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
    64'h0000_0000_FFFF_FFFF, 64'h5555_5555_AAAA_AAAA, 64'h0000_0001_8000_0000,
    64'h89AB_CDEF_0123_4567
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata;
  logic [0:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [63:0]       m_axis_tdata;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  bit              sender_idle_on;
  bit              sink_idle_on;
  bit              sink_hold_req;
  int unsigned     key_settings;
  tea_block_ledger ledger;

  tea_block_cipher_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap(bit enabled);
    int unsigned roll;
    if (!enabled) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_block(input logic op, input logic [31:0] left, input logic [31:0] right);
    int unsigned gap;
    gap = pick_gap(sender_idle_on);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {right, left};
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    ledger.note_request(op, left, right);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (ledger.pending_blocks.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_write_key(input logic [1:0] idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    ledger.set_key(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_check_key(input logic [1:0] idx);
    logic [31:0] value;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = ADDR_W'({idx, 2'b00});
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    value = prdata;
    ledger.check_key_readback(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                          input logic [31:0] k2, input logic [31:0] k3);
    int unsigned k;
    apb_write_key(KEY0_IDX, k0);
    apb_write_key(KEY1_IDX, k1);
    apb_write_key(KEY2_IDX, k2);
    apb_write_key(KEY3_IDX, k3);
    for (k = 0; k < 4; k++) begin
      apb_check_key(KEY_IDX_LIST[k]);
    end
    key_settings++;
  endtask

  task automatic send_random_blocks(input int unsigned count);
    cipher_block_t sealed;
    logic          op;
    logic [31:0]   left;
    logic [31:0]   right;
    int unsigned   n;
    for (n = 0; n < count; n++) begin
      op    = $urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT;
      left  = pick_word();
      right = pick_word();
      send_block(op, left, right);
      // Now and then decrypt what was just encrypted, so round trips are exercised.
      if (op == OP_ENCRYPT && $urandom_range(0, 3) == 0) begin
        sealed = ledger.cipher_block(op, left, right);
        send_block(OP_DECRYPT, sealed.left, sealed.right);
      end
      if ($urandom_range(0, 199) == 0) begin
        wait_drained();
      end
    end
  endtask

  // Result side: random stalls, one long hold-off on request.
  initial begin
    int unsigned stall_left;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        m_axis_tready = 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk_i);
        sink_hold_req = 1'b0;
      end
      m_axis_tready = (stall_left == 0);
      if (stall_left != 0) begin
        stall_left--;
      end else begin
        stall_left = pick_gap(sink_idle_on);
      end
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        ledger.check_block(m_axis_tdata[31:0], m_axis_tdata[63:32]);
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned k;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = OP_ENCRYPT;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    rst_ni         = 1'b0;
    sender_idle_on = 1'b1;
    sink_idle_on   = 1'b1;
    sink_hold_req  = 1'b0;
    key_settings   = 1;
    ledger         = new();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (k = 0; k < 4; k++) begin
      apb_check_key(KEY_IDX_LIST[k]);
    end
    for (k = 0; k < 7; k++) begin
      send_block(OP_ENCRYPT, EDGE_BLOCKS[k][31:0], EDGE_BLOCKS[k][63:32]);
      send_block(OP_DECRYPT, EDGE_BLOCKS[k][31:0], EDGE_BLOCKS[k][63:32]);
    end
    wait_drained();

    for (phase = 0; phase < 6; phase++) begin
      sender_idle_on = (phase != 3) && (phase != 4);
      sink_idle_on   = (phase != 4);
      case (phase)
        0: load_key('0, '0, '0, '0);
        1: load_key('1, '1, '1, '1);
        default: load_key($urandom, $urandom, $urandom, $urandom);
      endcase
      if (phase == 3) begin
        // The sink holds off while requests keep coming, so the chain fills and stalls.
        sink_hold_req = 1'b1;
        send_random_blocks(150);
      end else begin
        send_random_blocks((phase < 2) ? 40 : 80);
      end
      wait_drained();
    end
    repeat (70) @(negedge clk_i);

    $display("tb: %0d blocks sent (%0d decrypt), %0d results checked, %0d key settings",
             ledger.blocks_noted, ledger.decrypt_count, ledger.blocks_checked, key_settings);
    $display("tb: random stalls on both sides, one %0d-cycle sink hold-off, idle-free phases",
             SINK_HOLD_CYCLES);
    if (ledger.fail_count == 0 && ledger.pending_blocks.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
